@@ sv/bwlp_pkg.sv @@
package bwlp_pkg;

    localparam int COEFF_W   = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN = 2'd0,
        CFG_FB1  = 2'd1,
        CFG_FB2  = 2'd2
    } t_cfg_idx;

    localparam logic signed [COEFF_W-1:0] GAIN_RESET = 16'sd2833;
    localparam logic signed [COEFF_W-1:0] FB1_RESET  = -16'sd8685;
    localparam logic signed [COEFF_W-1:0] FB2_RESET  = 16'sd3632;

endpackage

@@ sv/bwlp_in_if.sv @@
interface bwlp_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          start_req;

    modport source (output valid, output sample_in, output start_req, input ready);
    modport sink   (input valid, input sample_in, input start_req, output ready);
endinterface

@@ sv/bwlp_out_if.sv @@
interface bwlp_out_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          saturated;

    modport source (output valid, output sample_out, output saturated, input ready);
    modport sink   (input valid, input sample_out, input saturated, output ready);
endinterface

@@ sv/butterworth_lowpass_biquad.sv @@
// Second-order low-pass biquad in direct form I. Each input transfer yields one output
// transfer of the rounded and saturated sum g*x0 + 2g*x1 + g*x2 - b1*y1 - b2*y2, with
// signed Q2.14 coefficients written through the configuration port while the filter is
// idle. The block takes one sample per clock cycle unless the output is stalled; each sample
// passes the input register and then the result register. That rate is set by the feedback
// loop: the five products, their sum, rounding and saturation are evaluated combinationally
// between the two registers. A set start_req zeroes the history before its sample.
module butterworth_lowpass_biquad #(
    parameter int SAMPLE_BITS     = 16,
    parameter int COEFF_FRAC_BITS = 14
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    bwlp_in_if.sink                               i_in,
    bwlp_out_if.source                            o_out,
    input  logic                                  i_cfg_we,
    input  logic [bwlp_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [bwlp_pkg::CFG_W-1:0]            i_cfg_data
);

    localparam int CW     = bwlp_pkg::COEFF_W;
    localparam int PROD_W = SAMPLE_BITS + CW;
    localparam int ACC_W  = PROD_W + 4;
    localparam logic signed [ACC_W-1:0] ROUND = ACC_W'(1) << (COEFF_FRAC_BITS - 1);

    logic signed [CW-1:0]          r_gain, r_fb1, r_fb2;
    logic                          r_in_valid;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic                          r_start;
    logic signed [SAMPLE_BITS-1:0] r_x1, r_x2, r_y1, r_y2;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_y;
    logic                          r_sat;

    logic                          advance;
    logic                          in_take;
    logic signed [SAMPLE_BITS-1:0] hx1, hx2, hy1, hy2;
    logic signed [PROD_W-1:0]      p0, p1, p2, p3, p4;
    logic signed [ACC_W-1:0]       acc, y_full;
    logic [ACC_W-SAMPLE_BITS:0]    hi;
    logic                          pos_ovf, neg_ovf;
    logic signed [SAMPLE_BITS-1:0] n_y;
    logic                          n_sat;

    assign advance     = !r_out_valid || o_out.ready;
    assign i_in.ready  = !r_in_valid || advance;
    assign in_take     = i_in.valid && i_in.ready;

    assign hx1 = r_start ? '0 : r_x1;
    assign hx2 = r_start ? '0 : r_x2;
    assign hy1 = r_start ? '0 : r_y1;
    assign hy2 = r_start ? '0 : r_y2;

    assign p0 = r_x * r_gain;
    assign p1 = hx1 * r_gain;
    assign p2 = hx2 * r_gain;
    assign p3 = hy1 * r_fb1;
    assign p4 = hy2 * r_fb2;

    assign acc = ACC_W'(p0) + (ACC_W'(p1) <<< 1) + ACC_W'(p2)
               - ACC_W'(p3) - ACC_W'(p4) + ROUND;
    assign y_full = acc >>> COEFF_FRAC_BITS;

    assign hi      = y_full[ACC_W-1:SAMPLE_BITS-1];
    assign pos_ovf = !y_full[ACC_W-1] && (|hi);
    assign neg_ovf = y_full[ACC_W-1] && !(&hi);

    always_comb begin
        n_sat = pos_ovf || neg_ovf;
        if (pos_ovf) begin
            n_y = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end else if (neg_ovf) begin
            n_y = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            n_y = y_full[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= bwlp_pkg::GAIN_RESET;
            r_fb1  <= bwlp_pkg::FB1_RESET;
            r_fb2  <= bwlp_pkg::FB2_RESET;
        end else if (i_cfg_we) begin
            case (bwlp_pkg::t_cfg_idx'(i_cfg_idx))
                bwlp_pkg::CFG_GAIN: r_gain <= i_cfg_data;
                bwlp_pkg::CFG_FB1:  r_fb1  <= i_cfg_data;
                bwlp_pkg::CFG_FB2:  r_fb2  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (in_take) begin
            r_x     <= i_in.sample_in;
            r_start <= i_in.start_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_x1        <= '0;
            r_x2        <= '0;
            r_y1        <= '0;
            r_y2        <= '0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_x1 <= r_x;
                r_x2 <= hx1;
                r_y1 <= n_y;
                r_y2 <= hy1;
            end
        end
        if (advance && r_in_valid) begin
            r_y   <= n_y;
            r_sat <= n_sat;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_y;
    assign o_out.saturated  = r_sat;

endmodule

@@ sv/bwlp_checker.sv @@
module bwlp_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [SAMPLE_BITS-1:0] i_sample_out,
    input logic                   i_saturated
);

    localparam logic [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Output valid after reset.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_sample_out) && $stable(i_saturated))
        else $error("Stalled output transfer changed.");

    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_saturated |-> (i_sample_out == SMAX) || (i_sample_out == SMIN))
        else $error("Saturated result is not at a range limit.");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("Input stalled while the output register is empty.");

endmodule

bind butterworth_lowpass_biquad bwlp_checker #(
    .SAMPLE_BITS(SAMPLE_BITS)
) u_bwlp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_sample_out (o_out.sample_out),
    .i_saturated  (o_out.saturated)
);

@@ tb/butterworth_lowpass_biquad_tb.sv @@
`timescale 1ns / 100ps

module butterworth_lowpass_biquad_tb;

    localparam int SW        = 16;
    localparam int FRAC      = 14;
    localparam int CW        = bwlp_pkg::CFG_W;
    localparam int IW        = bwlp_pkg::CFG_IDX_W;
    localparam int WDOG_MAX  = 5000;
    localparam int HOLD_LEN  = 400;
    localparam logic [IW-1:0] CFG_UNUSED = 2'd3;
    localparam logic signed [SW-1:0] SMAX = 16'sh7fff;
    localparam logic signed [SW-1:0] SMIN = 16'sh8000;

    typedef struct packed {
        logic signed [SW-1:0] sample;
        logic                 sat;
    } t_filt_result;

    class filter_scoreboard;
        logic signed [bwlp_pkg::COEFF_W-1:0] gain;
        logic signed [bwlp_pkg::COEFF_W-1:0] fb1;
        logic signed [bwlp_pkg::COEFF_W-1:0] fb2;
        logic signed [SW-1:0]      x1, x2, y1, y2;
        t_filt_result              expected_q[$];
        int                        errors;

        function new();
            gain   = bwlp_pkg::GAIN_RESET;
            fb1    = bwlp_pkg::FB1_RESET;
            fb2    = bwlp_pkg::FB2_RESET;
            x1     = '0;
            x2     = '0;
            y1     = '0;
            y2     = '0;
            errors = 0;
        endfunction

        function void set_coeff(logic [IW-1:0] idx, logic [CW-1:0] value);
            case (idx)
                bwlp_pkg::CFG_GAIN: gain = value;
                bwlp_pkg::CFG_FB1:  fb1 = value;
                bwlp_pkg::CFG_FB2:  fb2 = value;
                default:  ;
            endcase
        endfunction

        function void note_input(logic signed [SW-1:0] x0, logic start);
            longint       acc;
            longint       y;
            t_filt_result r;
            if (start) begin
                x1 = '0;
                x2 = '0;
                y1 = '0;
                y2 = '0;
            end
            acc = longint'(gain) * longint'(x0) + 2 * longint'(gain) * longint'(x1)
                + longint'(gain) * longint'(x2) - longint'(fb1) * longint'(y1)
                - longint'(fb2) * longint'(y2);
            acc = acc + (longint'(1) << (FRAC - 1));
            y = acc >>> FRAC;
            r.sat = 1'b0;
            if (y > longint'(SMAX)) begin
                y = longint'(SMAX);
                r.sat = 1'b1;
            end else if (y < longint'(SMIN)) begin
                y = longint'(SMIN);
                r.sat = 1'b1;
            end
            r.sample = y[SW-1:0];
            x2 = x1;
            x1 = x0;
            y2 = y1;
            y1 = r.sample;
            expected_q.push_back(r);
        endfunction

        function void check_result(logic signed [SW-1:0] sample, logic sat);
            t_filt_result r;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual sample_out %0d",
                         $time, sample);
                errors++;
            end else begin
                r = expected_q.pop_front();
                if (sample !== r.sample) begin
                    $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                             $time, r.sample, sample);
                    errors++;
                end
                if (sat !== r.sat) begin
                    $display("%0t: saturated mismatch, expected %0b, actual %0b",
                             $time, r.sat, sat);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [IW-1:0]        cfg_idx;
    logic [CW-1:0]        cfg_data;
    bit                   long_hold_req;
    int                   idle_cycles;
    filter_scoreboard     sb = new();

    bwlp_in_if  #(.SAMPLE_BITS(SW)) in_bus ();
    bwlp_out_if #(.SAMPLE_BITS(SW)) out_bus ();

    butterworth_lowpass_biquad #(
        .SAMPLE_BITS     (SW),
        .COEFF_FRAC_BITS (FRAC)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_bus),
        .o_out      (out_bus),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (in_bus.valid && in_bus.ready) begin
            sb.note_input(in_bus.sample_in, in_bus.start_req);
        end
        if (out_bus.valid && out_bus.ready) begin
            sb.check_result(out_bus.sample_out, out_bus.saturated);
        end
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_MAX) begin
            $display("%0t: no transfer for %0d cycles", $time, WDOG_MAX);
            $display("[butterworth_lowpass_biquad] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // The receiver cycles through stall patterns and takes one long hold-off on request.
    initial begin
        int mode;
        int len;
        out_bus.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                out_bus.ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
                long_hold_req = 1'b0;
            end else begin
                mode = $urandom_range(0, 3);
                len  = $urandom_range(16, 64);
                repeat (len) begin
                    case (mode)
                        0:       out_bus.ready <= 1'b1;
                        1:       out_bus.ready <= 1'($urandom_range(0, 1));
                        2:       out_bus.ready <= ($urandom_range(0, 3) == 0);
                        default: out_bus.ready <= ~out_bus.ready;
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    task automatic write_cfg(logic [IW-1:0] idx, logic [CW-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        sb.set_coeff(idx, value);
    endtask

    task automatic load_coeffs(logic [CW-1:0] g, logic [CW-1:0] b1,
                               logic [CW-1:0] b2);
        write_cfg(bwlp_pkg::CFG_GAIN, g);
        write_cfg(bwlp_pkg::CFG_FB1, b1);
        write_cfg(bwlp_pkg::CFG_FB2, b2);
        write_cfg(CFG_UNUSED, CW'($urandom));
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic idle_gap(int cycles);
        if (cycles > 0) begin
            in_bus.valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic send_sample(logic signed [SW-1:0] sample, logic start, int gap);
        in_bus.valid     <= 1'b1;
        in_bus.sample_in <= sample;
        in_bus.start_req <= start;
        do @(posedge i_clk); while (!in_bus.ready);
        idle_gap(gap);
    endtask

    task automatic drain();
        in_bus.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic signed [SW-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return SMAX;
            1:       return SMIN;
            2:       return SW'($urandom_range(0, 511)) - SW'(256);
            default: return SW'($urandom);
        endcase
    endfunction

    task automatic run_random(int count, bit gapless);
        int  sent;
        int  burst;
        logic start;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && sent < count; k++) begin
                start = (sent == 0) || ($urandom_range(0, 39) == 0);
                send_sample(pick_sample(), start, 0);
                sent++;
            end
            if (!gapless) begin
                idle_gap($urandom_range(0, 12));
            end
        end
    endtask

    initial begin
        logic [CW-1:0] g, b1, b2;
        i_rst_n          <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_idx          <= bwlp_pkg::CFG_GAIN;
        cfg_data         <= '0;
        in_bus.valid     <= 1'b0;
        in_bus.sample_in <= '0;
        in_bus.start_req <= 1'b0;
        long_hold_req     = 1'b0;
        idle_cycles      <= 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Step responses at the reset coefficients, with restarts mid-signal.
        send_sample(16'sd0, 1'b1, 0);
        repeat (4) send_sample(SMAX, 1'b0, $urandom_range(0, 2));
        repeat (4) send_sample(SMIN, 1'b0, 0);
        send_sample(SMAX, 1'b1, 1);
        send_sample(16'sd0, 1'b0, 0);
        send_sample(-16'sd1, 1'b0, 0);
        send_sample(16'sd1, 1'b0, 0);
        drain();

        // Extreme coefficients drive the sum far beyond the sample range.
        load_coeffs(16'h7fff, 16'h8000, 16'h7fff);
        send_sample(SMIN, 1'b1, 0);
        send_sample(SMAX, 1'b0, 0);
        send_sample(SMAX, 1'b0, 0);
        send_sample(SMIN, 1'b0, 0);
        send_sample(16'sd0, 1'b1, 0);
        send_sample(16'sd0, 1'b0, 0);
        drain();
        load_coeffs(16'h8000, 16'h7fff, 16'h8000);
        send_sample(SMAX, 1'b1, 0);
        send_sample(SMIN, 1'b0, 0);
        send_sample(SMAX, 1'b0, 0);
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: begin
                    g  = bwlp_pkg::GAIN_RESET;
                    b1 = bwlp_pkg::FB1_RESET;
                    b2 = bwlp_pkg::FB2_RESET;
                end
                1: begin
                    g = 16'h7fff; b1 = 16'h7fff; b2 = 16'h7fff;
                end
                2: begin
                    g = 16'h8000; b1 = 16'h8000; b2 = 16'h8000;
                end
                3: begin
                    g = 16'h0000; b1 = 16'h0000; b2 = 16'h0000;
                end
                4, 6, 8: begin
                    g  = CW'($urandom_range(0, 4000));
                    b1 = CW'(-$urandom_range(0, 30000));
                    b2 = CW'($urandom_range(0, 15000));
                end
                default: begin
                    g = CW'($urandom); b1 = CW'($urandom); b2 = CW'($urandom);
                end
            endcase
            load_coeffs(g, b1, b2);
            if (ph == 5) begin
                long_hold_req = 1'b1;
            end
            run_random(200, (ph == 5) || ($urandom_range(0, 3) == 0));
            drain();
        end

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("[butterworth_lowpass_biquad] OK");
        end else begin
            $display("[butterworth_lowpass_biquad] ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/bwlp_pkg.sv
sv/bwlp_in_if.sv
sv/bwlp_out_if.sv
sv/butterworth_lowpass_biquad.sv
sv/bwlp_checker.sv
tb/butterworth_lowpass_biquad_tb.sv
